[hdl/baq_pkg.sv]
// Shared types, widths and constants of the blockwise absmax quantizer.
package baq_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int QUANT_W     = 8;
	localparam int SCALE_W     = 17;
	localparam int CNT_W       = 7;
	localparam int BLK_LEN_W   = 7;
	localparam int ROW_LEN_W   = 13;
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH   = 2'd1;

	localparam logic [BLK_LEN_W-1:0] BLOCK_LENGTH_RST = 7'd32;
	localparam logic [ROW_LEN_W-1:0] ROW_LENGTH_RST   = 13'd64;

	localparam int DEF_BLOCK_MAX = 64;
	localparam int DEF_ROW_MAX   = 4096;

	// divider: dividend < 2^25, divisor <= 2^16, up to 18 quotient bits
	localparam int DIV_DEND_W   = 25;
	localparam int DIV_DSOR_W   = 17;
	localparam int DIV_SH_W     = 26;
	localparam int DIV_Q_W      = 18;
	localparam int DIV_CNT_W    = 4;
	localparam int PAIRS_WIDE   = 9;
	localparam int PAIRS_NARROW = 4;
	localparam int SHIFT_WIDE   = 2 * PAIRS_WIDE - 1;
	localparam int SHIFT_NARROW = 2 * PAIRS_NARROW - 1;

	localparam logic [DIV_DSOR_W-1:0] SCALE_DIVISOR = 17'd254;
	localparam logic [8:0]            SCALE_BIAS    = 9'd127;
	localparam logic [SCALE_W-1:0]    ZERO_SCALE    = 17'd65536;
	localparam logic [6:0]            QMAX          = 7'd127;

	typedef struct packed {
		logic                 bank;
		logic [CNT_W-1:0]     count;
		logic [SAMPLE_W-1:0]  absmax;
		logic                 row_end;
	} desc_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SCALE,
		B_LOAD,
		B_DIV,
		B_EMIT
	} back_state_t;

endpackage

[hdl/blockwise_absmax_int8_quantizer.sv]
// Intake: one sample word per cycle while one of two block buffers is free.
// After the closing sample the descriptor is queued, then the scale division runs
// (not for a zero block), then each result word takes a load, a divider run and
// an emit, only load and emit in a zero block; output stalls hold the emit.
// Throughput is set by the shared two-bit-per-cycle divider in the back end.
// Reset clears counters, queue and output valid, and sets both registers to
// their defaults; the sample buffer is not cleared.
module blockwise_absmax_int8_quantizer import baq_pkg::*; #(
	parameter int BLOCK_MAX = DEF_BLOCK_MAX,
	parameter int ROW_MAX   = DEF_ROW_MAX
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [SAMPLE_W-1:0]   sample,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [QUANT_W-1:0]    quant_value,
	output logic [SCALE_W-1:0]    block_scale,
	output logic                  last_of_block,
	output logic                  last_of_row
);

	localparam int IW = (BLOCK_MAX > 1) ? $clog2(BLOCK_MAX) : 1;
	localparam int AW = IW + 1;

	logic                mem_we;
	logic [AW-1:0]       mem_addr;
	logic [SAMPLE_W-1:0] mem_data;
	logic                push;
	desc_t               push_desc;
	logic                pop;
	desc_t               head;
	logic                head_valid;
	logic                q_full;

	baq_front #(
		.BLOCK_MAX (BLOCK_MAX),
		.ROW_MAX   (ROW_MAX)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.mem_we    (mem_we),
		.mem_addr  (mem_addr),
		.mem_data  (mem_data),
		.push      (push),
		.push_desc (push_desc),
		.q_full    (q_full)
	);

	baq_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (q_full)
	);

	baq_back #(
		.BLOCK_MAX (BLOCK_MAX)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.mem_we        (mem_we),
		.mem_addr      (mem_addr),
		.mem_data      (mem_data),
		.head          (head),
		.head_valid    (head_valid),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.quant_value   (quant_value),
		.block_scale   (block_scale),
		.last_of_block (last_of_block),
		.last_of_row   (last_of_row)
	);

endmodule

[hdl/baq_queue.sv]
// Two-entry queue of closed-block descriptors between front and back.
module baq_queue import baq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	input  logic  pop,
	output desc_t head,
	output logic  head_valid,
	output logic  full
);

	desc_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign head       = ent_q[rd_ptr_q];
	assign head_valid = (cnt_q != 2'd0);
	assign full       = (cnt_q == 2'd2);

endmodule

[hdl/baq_front.sv]
// Front end: config registers, sample intake, block/row tracking, buffer writes.
module baq_front import baq_pkg::*; #(
	parameter int BLOCK_MAX = DEF_BLOCK_MAX,
	parameter int ROW_MAX   = DEF_ROW_MAX,
	localparam int IW  = (BLOCK_MAX > 1) ? $clog2(BLOCK_MAX) : 1,
	localparam int AW  = IW + 1,
	localparam int CCW = $clog2(ROW_MAX + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [SAMPLE_W-1:0]   sample,
	output logic                  mem_we,
	output logic [AW-1:0]         mem_addr,
	output logic [SAMPLE_W-1:0]   mem_data,
	output logic                  push,
	output desc_t                 push_desc,
	input  logic                  q_full
);

	localparam int EW = (CCW > ROW_LEN_W) ? CCW : ROW_LEN_W;

	logic [BLK_LEN_W-1:0] block_length_q;
	logic [ROW_LEN_W-1:0] row_length_q;
	logic [CNT_W-1:0]     fill_q;
	logic [CCW-1:0]       col_q;
	logic [SAMPLE_W-1:0]  amax_q;
	logic                 bank_q;

	logic                 accept;
	logic [SAMPLE_W-1:0]  mag;
	logic [SAMPLE_W-1:0]  amax_new;
	logic [CNT_W-1:0]     eff_block;
	logic [CNT_W-1:0]     fill_next;
	logic [EW-1:0]        row_x;
	logic [EW-1:0]        row_cap;
	logic [EW-1:0]        eff_row;
	logic [EW-1:0]        col_next;
	logic                 row_end;
	logic                 block_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_length_q <= BLOCK_LENGTH_RST;
			row_length_q   <= ROW_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BLOCK_LENGTH: block_length_q <= cfg_data[BLK_LEN_W-1:0];
				CFG_ROW_LENGTH:   row_length_q   <= cfg_data[ROW_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		mag      = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
		amax_new = (mag > amax_q) ? mag : amax_q;

		if (block_length_q == '0)
			eff_block = CNT_W'(1);
		else if (block_length_q > CNT_W'(BLOCK_MAX))
			eff_block = CNT_W'(BLOCK_MAX);
		else
			eff_block = block_length_q;

		row_x   = EW'(row_length_q);
		row_cap = EW'(ROW_MAX);
		if (row_x == '0)
			eff_row = EW'(1);
		else if (row_x > row_cap)
			eff_row = row_cap;
		else
			eff_row = row_x;

		fill_next = fill_q + 1'b1;
		col_next  = EW'(col_q) + 1'b1;
		row_end   = (col_next >= eff_row);
		block_end = row_end || (fill_next >= eff_block);
	end

	assign mem_we   = accept;
	assign mem_addr = {bank_q, fill_q[IW-1:0]};
	assign mem_data = sample;

	assign push              = accept && block_end;
	assign push_desc.bank    = bank_q;
	assign push_desc.count   = fill_next;
	assign push_desc.absmax  = amax_new;
	assign push_desc.row_end = row_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			col_q  <= '0;
			amax_q <= '0;
			bank_q <= 1'b0;
		end else if (accept) begin
			col_q <= row_end ? '0 : col_next[CCW-1:0];
			if (block_end) begin
				fill_q <= '0;
				amax_q <= '0;
				bank_q <= ~bank_q;
			end else begin
				fill_q <= fill_next;
				amax_q <= amax_new;
			end
		end
	end

endmodule

[hdl/baq_div.sv]
// Restoring divider, two quotient bits per cycle, shared for scale and samples.
module baq_div import baq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  wide,
	input  logic [DIV_DEND_W-1:0] dividend,
	input  logic [DIV_DSOR_W-1:0] divisor,
	output logic                  last,
	output logic [DIV_Q_W-1:0]    quotient
);

	logic [DIV_SH_W-1:0]  rem_q;
	logic [DIV_SH_W-1:0]  dsh_q;
	logic [DIV_Q_W-1:0]   quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;

	logic                 b1;
	logic                 b2;
	logic [DIV_SH_W-1:0]  r1;
	logic [DIV_SH_W-1:0]  r2;
	logic [DIV_SH_W-1:0]  d1;

	always_comb begin
		b1 = (rem_q >= dsh_q);
		r1 = b1 ? (rem_q - dsh_q) : rem_q;
		d1 = dsh_q >> 1;
		b2 = (r1 >= d1);
		r2 = b2 ? (r1 - d1) : r1;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DIV_SH_W'(dividend);
			dsh_q <= wide ? (DIV_SH_W'(divisor) << SHIFT_WIDE)
			              : (DIV_SH_W'(divisor) << SHIFT_NARROW);
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= r2;
			dsh_q <= dsh_q >> 2;
			quo_q <= {quo_q[DIV_Q_W-3:0], b1, b2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= wide ? DIV_CNT_W'(PAIRS_WIDE) : DIV_CNT_W'(PAIRS_NARROW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) busy_q <= 1'b0;
		end
	end

	// quotient is final after the edge at which last is high
	assign last     = busy_q && (cnt_q == DIV_CNT_W'(1));
	assign quotient = quo_q;

endmodule

[hdl/baq_back.sv]
// Back end: sample buffer, block scale, per-sample quantize and output register.
module baq_back import baq_pkg::*; #(
	parameter int BLOCK_MAX = DEF_BLOCK_MAX,
	localparam int IW = (BLOCK_MAX > 1) ? $clog2(BLOCK_MAX) : 1,
	localparam int AW = IW + 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                mem_we,
	input  logic [AW-1:0]       mem_addr,
	input  logic [SAMPLE_W-1:0] mem_data,
	input  desc_t               head,
	input  logic                head_valid,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [QUANT_W-1:0]  quant_value,
	output logic [SCALE_W-1:0]  block_scale,
	output logic                last_of_block,
	output logic                last_of_row
);

	logic [SAMPLE_W-1:0] sbuf_q [2**AW];
	logic [SAMPLE_W-1:0] rd_data_q;

	back_state_t         state_q, state_d;
	logic [IW-1:0]       idx_q, idx_d;
	logic [SCALE_W-1:0]  scale_q;

	logic                out_valid_q;
	logic [QUANT_W-1:0]  quant_q;
	logic [SCALE_W-1:0]  scale_out_q;
	logic                lob_q;
	logic                lor_q;

	logic                  div_start;
	logic                  div_wide;
	logic [DIV_DEND_W-1:0] div_dividend;
	logic [DIV_DSOR_W-1:0] div_divisor;
	logic                  div_last;
	logic [DIV_Q_W-1:0]    div_quo;

	logic                  zero_blk;
	logic                  is_last;
	logic                  out_free;
	logic                  out_load;
	logic [SAMPLE_W-1:0]   mag;
	logic [DIV_DEND_W-1:0] num;
	logic [6:0]            qmag;
	logic [QUANT_W-1:0]    qval;

	always_ff @(posedge clk) begin
		if (mem_we) sbuf_q[mem_addr] <= mem_data;
		rd_data_q <= sbuf_q[{head.bank, idx_d}];
	end

	baq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.wide     (div_wide),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.last     (div_last),
		.quotient (div_quo)
	);

	always_comb begin
		zero_blk = (head.absmax == '0);
		is_last  = ((CNT_W'(idx_q) + 1'b1) == head.count);
		out_free = !out_valid_q || !out_stall;

		mag = rd_data_q[SAMPLE_W-1] ? (~rd_data_q + 1'b1) : rd_data_q;
		// 254*mag + absmax, i.e. 2*mag*127 plus half the divisor for rounding
		num = ({1'b0, mag, 8'b0} - {8'b0, mag, 1'b0}) + DIV_DEND_W'(head.absmax);

		qmag = (div_quo[DIV_Q_W-1:7] != '0) ? QMAX : div_quo[6:0];
		if (zero_blk)
			qval = '0;
		else if (rd_data_q[SAMPLE_W-1])
			qval = ~{1'b0, qmag} + 1'b1;
		else
			qval = {1'b0, qmag};
	end

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		div_start    = 1'b0;
		div_wide     = 1'b0;
		div_dividend = {head.absmax, SCALE_BIAS};
		div_divisor  = SCALE_DIVISOR;
		pop          = 1'b0;
		out_load     = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (head_valid) begin
					if (zero_blk) begin
						state_d = B_LOAD;
					end else begin
						div_start = 1'b1;
						div_wide  = 1'b1;
						state_d   = B_SCALE;
					end
				end
			end
			B_SCALE: begin
				if (div_last) state_d = B_LOAD;
			end
			B_LOAD: begin
				if (zero_blk) begin
					state_d = B_EMIT;
				end else begin
					div_start    = 1'b1;
					div_dividend = num;
					div_divisor  = {head.absmax, 1'b0};
					state_d      = B_DIV;
				end
			end
			B_DIV: begin
				if (div_last) state_d = B_EMIT;
			end
			B_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					if (is_last) begin
						pop     = 1'b1;
						idx_d   = '0;
						state_d = B_IDLE;
					end else begin
						idx_d   = idx_q + 1'b1;
						state_d = B_LOAD;
					end
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	// scale quotient is still held on the first sample's load
	always_ff @(posedge clk) begin
		if (state_q == B_LOAD && idx_q == '0)
			scale_q <= zero_blk ? ZERO_SCALE : div_quo[SCALE_W-1:0];
		if (out_load) begin
			quant_q     <= qval;
			scale_out_q <= scale_q;
			lob_q       <= is_last;
			lor_q       <= head.row_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	assign out_valid     = out_valid_q;
	assign quant_value   = quant_q;
	assign block_scale   = scale_out_q;
	assign last_of_block = lob_q;
	assign last_of_row   = lor_q;

endmodule

[hdl/baq_checker.sv]
// Port-level checks on the quantizer output, bound to the top level.
module baq_checker import baq_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [QUANT_W-1:0]    quant_value,
	input logic [SCALE_W-1:0]    block_scale,
	input logic                  last_of_block,
	input logic                  last_of_row
);

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(quant_value)
			&& $stable(block_scale) && $stable(last_of_block) && $stable(last_of_row))
		else $error("stalled output word changed");

	a_no_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> quant_value != 8'h80)
		else $error("quant value -128 emitted");

	// a valid word never carries unknown bits
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown({quant_value, block_scale, last_of_block, last_of_row}))
		else $error("unknown bits in output word");

	a_scale_rng: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> block_scale <= 17'd66052)
		else $error("block scale out of range");

	a_rst: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("output valid during reset");

endmodule

bind blockwise_absmax_int8_quantizer baq_checker u_baq_checker (.*);

[verif/blockwise_absmax_int8_quantizer_tb.sv]
// Self-checking testbench of the blockwise absmax int8 quantizer.
module blockwise_absmax_int8_quantizer_tb;
	import baq_pkg::*;

	typedef struct packed {
		logic [QUANT_W-1:0] q;
		logic [SCALE_W-1:0] scale;
		logic               lob;
		logic               lor;
	} quant_word_t;

	typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [15:0]          val;
		bit                   typed;
		logic [QUANT_W-1:0]   w_q;
		logic [SCALE_W-1:0]   w_scale;
		logic                 w_lob;
		logic                 w_lor;
	} stim_row_t;

	// indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
	localparam int DIR_ROWS = 22;
	localparam int IDLE_SETTLE = 20;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [SAMPLE_W-1:0]   sample = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [QUANT_W-1:0]    quant_value;
	logic [SCALE_W-1:0]    block_scale;
	logic                  last_of_block;
	logic                  last_of_row;

	// predictor state
	logic [BLK_LEN_W-1:0] blk_len_reg = BLOCK_LENGTH_RST;
	logic [ROW_LEN_W-1:0] row_len_reg = ROW_LENGTH_RST;
	logic [15:0]          blk_buf [DEF_BLOCK_MAX];
	int unsigned          fill_cnt = 0;
	int unsigned          col_cnt = 0;
	int unsigned          blk_amax = 0;

	quant_word_t pending_words[$];
	stim_row_t   dir_tab [DIR_ROWS];
	int          errors = 0;
	int          word_no = 0;
	int          stall_left = 0;
	bit          idling = 1'b1;

	blockwise_absmax_int8_quantizer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample       (sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.quant_value  (quant_value),
		.block_scale  (block_scale),
		.last_of_block(last_of_block),
		.last_of_row  (last_of_row)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unsigned magnitude(logic [15:0] raw);
		return raw[15] ? (32'd65536 - {16'd0, raw}) : {16'd0, raw};
	endfunction

	// round half away from zero of x*127/amax, clamped, as int8 pattern
	function automatic logic [QUANT_W-1:0] quant_of(logic [15:0] raw, int unsigned amax);
		int unsigned q;
		if (amax == 0)
			return '0;
		q = (2 * magnitude(raw) * 127 + amax) / (2 * amax);
		if (q > 127)
			q = 127;
		return raw[15] ? 8'(-q) : 8'(q);
	endfunction

	task automatic predict_sample(input logic [15:0] raw);
		int unsigned mag, eb, er, scale;
		bit row_end, blk_end;
		quant_word_t w;
		mag = magnitude(raw);
		eb = (blk_len_reg == 0) ? 1 : (blk_len_reg > DEF_BLOCK_MAX) ? DEF_BLOCK_MAX : blk_len_reg;
		er = (row_len_reg == 0) ? 1 : (row_len_reg > DEF_ROW_MAX) ? DEF_ROW_MAX : row_len_reg;
		blk_buf[fill_cnt] = raw;
		fill_cnt++;
		if (mag > blk_amax)
			blk_amax = mag;
		col_cnt++;
		row_end = (col_cnt >= er);
		blk_end = row_end || (fill_cnt >= eb);
		if (blk_end) begin
			scale = (blk_amax == 0) ? 65536 : (blk_amax * 512 + 127) / 254;
			for (int k = 0; k < fill_cnt; k++) begin
				w.q = quant_of(blk_buf[k], blk_amax);
				w.scale = SCALE_W'(scale);
				w.lob = (k == fill_cnt - 1);
				w.lor = row_end;
				pending_words.push_back(w);
			end
			fill_cnt = 0;
			blk_amax = 0;
			if (row_end)
				col_cnt = 0;
		end
	endtask

	// drive one sample word, with an optional gap before it
	task automatic send_sample(input logic [15:0] v);
		if (idling && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= v;
		do @(posedge clk); while (in_stall);
		predict_sample(v);
	endtask

	// registers change only once every pending word is out
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (IDLE_SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_BLOCK_LENGTH: blk_len_reg = data[BLK_LEN_W-1:0];
			CFG_ROW_LENGTH:   row_len_reg = data;
			default: ;
		endcase
	endtask

	function automatic logic [15:0] pick_sample(bit sparse);
		logic [7:0] lo;
		lo = 8'($urandom);
		if (sparse)
			return ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 6)) - 16'd3 : 16'h0000;
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'h8000;
			2: return 16'h7FFF;
			3: return 16'($urandom_range(0, 32)) - 16'd16;
			4: return {{8{lo[7]}}, lo};
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("mismatch word %0d %s: got %0d want %0d", word_no, what, got, want);
	endtask

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (idling && $urandom_range(0, 3) == 0) begin
			stall_left <= $urandom_range(0, 4);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		quant_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				report_mismatch("unexpected word, quant_value", quant_value, 0);
			end else begin
				want = pending_words.pop_front();
				if (quant_value !== want.q)
					report_mismatch("quant_value", quant_value, want.q);
				if (block_scale !== want.scale)
					report_mismatch("block_scale", block_scale, want.scale);
				if (last_of_block !== want.lob)
					report_mismatch("last_of_block", last_of_block, want.lob);
				if (last_of_row !== want.lor)
					report_mismatch("last_of_row", last_of_row, want.lor);
			end
			word_no++;
		end
	end

	initial begin
		#(20 * 600000);
		$display("blockwise_absmax_int8_quantizer regression: fail");
		$finish;
	end

	initial begin
		logic [BLK_LEN_W-1:0] blk;
		logic [ROW_LEN_W-1:0] row;
		bit sparse;
		dir_tab = '{
			// reset setting, then block length zero written mid-block
			'{ROW_SAMPLE, CFG_BLOCK_LENGTH, 16'h0100, 0, 0, 0, 0, 0},
			'{ROW_CFG,    CFG_BLOCK_LENGTH, 16'h0000, 0, 0, 0, 0, 0},
			'{ROW_SAMPLE, CFG_BLOCK_LENGTH, 16'h8000, 0, 0, 0, 0, 0},
			'{ROW_SAMPLE, CFG_BLOCK_LENGTH, 16'h0000, 1, 8'h00, 17'd65536, 1, 0},
			'{ROW_SAMPLE, CFG_BLOCK_LENGTH, 16'h8000, 1, 8'h81, 17'd66052, 1, 0},
			'{ROW_SAMPLE, CFG_BLOCK_LENGTH, 16'h7FFF, 1, 8'h7F, 17'd66050, 1, 0},
			'{ROW_SAMPLE, CFG_BLOCK_LENGTH, 16'h0001, 1, 8'h7F, 17'd2, 1, 0},
			'{ROW_SAMPLE, CFG_BLOCK_LENGTH, 16'hFFFF, 1, 8'h81, 17'd2, 1, 0},
			// row length zero: every word closes a row
			'{ROW_CFG,    CFG_ROW_LENGTH,   16'h0000, 0, 0, 0, 0, 0},
			'{ROW_SAMPLE, CFG_BLOCK_LENGTH, 16'h0000, 1, 8'h00, 17'd65536, 1, 1},
			'{ROW_SAMPLE, CFG_BLOCK_LENGTH, 16'h8001, 1, 8'h81, 17'd66050, 1, 1},
			// zero block, then a short block at the row end
			'{ROW_CFG,    CFG_BLOCK_LENGTH, 16'h0003, 0, 0, 0, 0, 0},
			'{ROW_CFG,    CFG_ROW_LENGTH,   16'h0005, 0, 0, 0, 0, 0},
			'{ROW_SAMPLE, CFG_BLOCK_LENGTH, 16'h0000, 0, 0, 0, 0, 0},
			'{ROW_SAMPLE, CFG_BLOCK_LENGTH, 16'h0000, 0, 0, 0, 0, 0},
			'{ROW_SAMPLE, CFG_BLOCK_LENGTH, 16'h0000, 0, 0, 0, 0, 0},
			'{ROW_SAMPLE, CFG_BLOCK_LENGTH, 16'h1234, 0, 0, 0, 0, 0},
			'{ROW_SAMPLE, CFG_BLOCK_LENGTH, 16'hEDCC, 0, 0, 0, 0, 0},
			// exact halves round away from zero
			'{ROW_CFG,    CFG_ROW_LENGTH,   16'h0040, 0, 0, 0, 0, 0},
			'{ROW_SAMPLE, CFG_BLOCK_LENGTH, 16'h00FE, 0, 0, 0, 0, 0},
			'{ROW_SAMPLE, CFG_BLOCK_LENGTH, 16'h0001, 0, 0, 0, 0, 0},
			'{ROW_SAMPLE, CFG_BLOCK_LENGTH, 16'hFFFF, 0, 0, 0, 0, 0}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG) begin
				cfg_write(dir_tab[i].idx, CFG_DATA_W'(dir_tab[i].val));
			end else begin
				send_sample(dir_tab[i].val);
				if (dir_tab[i].typed)
					pending_words[pending_words.size() - 1] = '{dir_tab[i].w_q,
						dir_tab[i].w_scale, dir_tab[i].w_lob, dir_tab[i].w_lor};
			end
		end

		for (int ph = 0; ph < 14; ph++) begin
			case (ph)
				0: begin blk = 7'd1;   row = 13'd1;    end
				1: begin blk = 7'd64;  row = 13'd4096; end
				2: begin blk = 7'd127; row = 13'h1FFF; end
				3: begin blk = 7'd0;   row = 13'd0;    end
				4: begin blk = 7'd7;   row = 13'd20;   end
				default: begin
					blk = 7'($urandom_range(0, 127));
					row = ($urandom_range(0, 3) == 0) ? 13'($urandom) : 13'($urandom_range(1, 100));
				end
			endcase
			idling = ($urandom_range(0, 3) != 0);
			// upper data bits are don't-care for the block length
			if (ph < 5 || $urandom_range(0, 2) != 0) begin
				cfg_write(CFG_BLOCK_LENGTH, {6'($urandom), blk});
				cfg_write(CFG_ROW_LENGTH, row);
			end else if ($urandom_range(0, 1) == 0) begin
				cfg_write(CFG_BLOCK_LENGTH, {6'($urandom), blk});
			end else begin
				cfg_write(CFG_ROW_LENGTH, row);
			end
			if ($urandom_range(0, 3) == 0)
				cfg_write($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, 13'($urandom));
			sparse = ($urandom_range(0, 4) == 0);
			repeat (28) send_sample(pick_sample(sparse));
		end

		// one full block at the saturated lengths, no idling from here on
		idling = 1'b0;
		cfg_write(CFG_BLOCK_LENGTH, 13'h1FFF);
		cfg_write(CFG_ROW_LENGTH, 13'h1FFF);
		repeat (DEF_BLOCK_MAX + 8) send_sample(pick_sample(1'b0));

		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("blockwise_absmax_int8_quantizer regression: pass");
		else
			$display("blockwise_absmax_int8_quantizer regression: fail");
		$finish;
	end

endmodule
